// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, ignored while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/sida_pkg.sv -----
`default_nettype none

package sida_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGITS  = 10;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int CHAR_W  = 7;
  localparam int STEP_W  = $clog2(VALUE_W + 1);
  localparam int IDX_W   = $clog2(DIGITS);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_HAND
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } dabble_stat_t;

  typedef struct packed {
    logic load;
    logic negative;
  } emit_cmd_t;

endpackage

`default_nettype wire

// ----- src/sida_dabble.sv -----
`default_nettype none
`include "assert_macros.svh"

module sida_dabble import sida_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [VALUE_W-1:0] mag,
  output logic [BCD_W-1:0]        bcd,
  output dabble_stat_t            stat
);

  logic [VALUE_W-1:0] bin;
  logic [STEP_W-1:0]  cnt;
  logic [BCD_W-1:0]   bcd_adj;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    logic [3:0] nib;
    nib = '0;
    for (int i = 0; i < DIGITS; i++) begin
      nib = bcd[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= STEP_W'(VALUE_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (cnt != '0) begin
      bin <= {bin[VALUE_W-2:0], 1'b0};
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
    end
  end

  assign stat.busy = (cnt != '0);
  assign stat.done = (cnt == STEP_W'(1));

  `ASSERT_CLK(a_done_ends_busy, stat.done && !start |=> !stat.busy, "dabble still busy after done")
  `ASSERT_CLK(a_no_restart, stat.busy |-> !start, "dabble restarted while busy")

endmodule

`default_nettype wire

// ----- src/sida_emit.sv -----
`default_nettype none
`include "assert_macros.svh"

module sida_emit import sida_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire emit_cmd_t         cmd,
  input  wire logic [BCD_W-1:0]  bcd_in,
  output logic                   active,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [CHAR_W-1:0]      character,
  output logic                   last
);

  logic [BCD_W-1:0]  bcd;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  top_idx;
  logic              minus_pend;
  logic              advance;
  logic [3:0]        digit;

  // Most significant nonzero digit; zero still shows one digit.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_in[i*4 +: 4] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign digit   = bcd[{idx, 2'b00} +: 4];
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      minus_pend <= 1'b0;
    end else if (cmd.load) begin
      active     <= 1'b1;
      minus_pend <= cmd.negative;
    end else if (active && advance) begin
      if (minus_pend) begin
        minus_pend <= 1'b0;
      end else if (idx == '0) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bcd <= bcd_in;
      idx <= top_idx;
    end else if (active && advance && !minus_pend && idx != '0) begin
      idx <= idx - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= active;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && active) begin
      if (minus_pend) begin
        character <= ASCII_MINUS;
        last      <= 1'b0;
      end else begin
        character <= ASCII_ZERO + {3'b000, digit};
        last      <= (idx == '0);
      end
    end
  end

  `ASSERT_CLK(a_load_when_free, cmd.load |-> !active, "load while characters remain")
  `ASSERT_CLK(a_idx_range, active |-> idx < IDX_W'(DIGITS), "digit index out of range")

endmodule

`default_nettype wire

// ----- src/signed_int_to_decimal_ascii_top.sv -----
// Converts one signed 32-bit integer per input beat into its decimal ASCII
// text, one character per output beat, most significant first, with a
// leading '-' for negative values and last set on the final character.
// An item is taken in IDLE, its magnitude runs through a single
// shift-and-add-3 binary-to-BCD unit in CONV, and HAND then hands the
// digits to the character emitter once it is free, so a new item is taken
// only after the last one has been handed off. The emitter sends 1 to 11
// characters at one per cycle while out_stall is low, overlapped with the
// conversion of the next item; in_stall is high from acceptance until the handoff.
`default_nettype none
`include "assert_macros.svh"

module signed_int_to_decimal_ascii_top import sida_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [VALUE_W-1:0]  value,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CHAR_W-1:0]        character,
  output logic                     last
);

  state_t             state;
  state_t             state_next;
  logic               start;
  logic               negative;
  logic [VALUE_W-1:0] mag;
  logic [BCD_W-1:0]   bcd;
  dabble_stat_t       dab_stat;
  emit_cmd_t          cmd;
  logic               emit_active;

  // Two's complement negate works for the most negative value as unsigned.
  assign mag = value[VALUE_W-1] ? (~value + 1'b1) : value;

  always_ff @(posedge clk) begin
    if (start) begin
      negative <= value[VALUE_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CONV;
      end
      ST_CONV: begin
        if (dab_stat.done) state_next = ST_HAND;
      end
      ST_HAND: begin
        if (!emit_active) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    start        = 1'b0;
    cmd.load     = 1'b0;
    cmd.negative = negative;
    case (state)
      ST_IDLE: begin
        // No beat is taken while reset is held.
        in_stall = rst;
        start    = in_valid && !rst;
      end
      ST_HAND: begin
        cmd.load = !emit_active;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  sida_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag),
    .bcd   (bcd),
    .stat  (dab_stat)
  );

  sida_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .bcd_in    (bcd),
    .active    (emit_active),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  `ASSERT_CLK(a_done_in_conv, dab_stat.done |-> state == ST_CONV, "conversion ended outside CONV")
  `ASSERT_CLK(a_conv_busy, state == ST_CONV |-> dab_stat.busy, "CONV without a running unit")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench import sida_pkg::*; ();

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              is_last;
  } text_char_t;

  class text_scoreboard;
    text_char_t  pending_text[$];
    int unsigned mismatches;
    int unsigned values_seen;
    int unsigned negatives_seen;
    int unsigned chars_seen;

    function int unsigned outstanding();
      return pending_text.size();
    endfunction

    // Expand one accepted value into the characters of its decimal text.
    function void note_value(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [3:0]         digit_buf[DIGITS];
      int                 n;
      text_char_t         c;
      n = 0;
      // The magnitude is unsigned, so the most negative value does not overflow.
      mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
      do begin
        digit_buf[n] = 4'(mag % 10);
        mag = mag / 10;
        n++;
      end while (mag != 0 && n < DIGITS);
      if (v[VALUE_W-1]) begin
        c.code = ASCII_MINUS;
        c.is_last = 1'b0;
        pending_text.push_back(c);
        negatives_seen++;
      end
      for (int k = n - 1; k >= 0; k--) begin
        c.code = ASCII_ZERO + {3'b000, digit_buf[k]};
        c.is_last = (k == 0);
        pending_text.push_back(c);
      end
      values_seen++;
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_char(logic [CHAR_W-1:0] code, logic flag);
      text_char_t want;
      chars_seen++;
      if (pending_text.size() == 0) begin
        report($sformatf("unexpected character %0d last=%0b", code, flag));
      end else begin
        want = pending_text.pop_front();
        if (code !== want.code)
          report($sformatf("character %0d, expected %0d", code, want.code));
        if (flag !== want.is_last)
          report($sformatf("last %0b, expected %0b (character %0d)", flag, want.is_last,
                           want.code));
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall;
  logic [CHAR_W-1:0]  character;
  logic               last;

  logic               idling_on;
  int                 stall_left;

  text_scoreboard sb = new();

  signed_int_to_decimal_ascii_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .character (character),
    .last      (last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Offer one value and hold it until the block takes it; afterwards the
  // sender may go quiet for a burst while idling is enabled.
  task send_value(input logic [VALUE_W-1:0] v);
    in_valid = 1'b1;
    value = v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_value(v);
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  task drain_text();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // Output side stalls in random bursts.
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (idling_on && $urandom_range(0, 9) == 0)
          stall_left = $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_char(character, last);
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int                 corner_values[$];
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] mag;
    longint unsigned    lo;
    longint unsigned    hi;
    int                 len;
    int                 random_count;

    corner_values = '{0, 1, -1, 9, 10, -10, 99, 100, -100, 2147483647, 32'sh8000_0000,
                      -2147483647, 999999999, 1000000000, -999999999, 1234567890,
                      -1234567890, 32'h5555_5555, 32'hAAAA_AAAA, 7, -5};
    random_count = 240;

    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    idling_on = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    idling_on = 1'b1;
    foreach (corner_values[i]) send_value(VALUE_W'(corner_values[i]));
    drain_text();

    for (int i = 0; i < random_count; i++) begin
      // Quiet stretches in all but every third block of twenty, and none near the end.
      idling_on = ((i / 20) % 3 != 2) && (i < random_count - 40);
      case ($urandom_range(0, 3))
        0: v = $urandom();
        1: begin
          // Uniform digit count, then a magnitude with exactly that many digits.
          len = $urandom_range(1, DIGITS);
          hi = 1;
          repeat (len) hi = hi * 10;
          lo = (len == 1) ? 0 : hi / 10;
          hi = hi - 1;
          if (hi > 64'd2147483648) hi = 64'd2147483648;
          mag = $urandom_range(hi[31:0], lo[31:0]);
          v = $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
          if (mag == 32'h8000_0000) v = mag;
        end
        2: begin
          mag = $urandom_range(0, 20);
          v = $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
        end
        default: v = $urandom_range(0, 1) ? (32'h7FFF_FFFF - $urandom_range(0, 3))
                                            : (32'h8000_0000 + $urandom_range(0, 3));
      endcase
      send_value(v);
      if (i == random_count / 2) drain_text();
    end

    drain_text();
    repeat (64) @(negedge clk);

    $display("Converted %0d values (%0d negative) and checked %0d characters.",
             sb.values_seen, sb.negatives_seen, sb.chars_seen);
    $display("Zero, both 32-bit extremes, every digit count and bursty stalls on both sides.");
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/sida_pkg.sv
src/sida_dabble.sv
src/sida_emit.sv
src/signed_int_to_decimal_ascii_top.sv
tb/sv/testbench.sv
